// ===== rtl/core/dca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dca_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ARG_LOG2     = 3;
    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_Q     = 30;

    // pipelined iterative units
    localparam int SQ_STEPS = 31;  // sqrt result bits
    localparam int UQ_BITS  = 17;  // unit direction quotient bits
    localparam int AQ_BITS  = 19;  // tanh argument quotient bits

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_ANGLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADVANCING_ANGLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECEDING_ANGLE  = 3'd3;

    localparam logic [23:0] ANGLE_RESET = 24'd5898240;

    // unsigned quotient by shift and subtract, used only while building the table
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        int b;
        q = 64'd0;
        r = 64'd0;
        for (b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atanh(2^-i) in q30 from its power series, evaluated in q60
    function automatic longint atanh_pow2(input int i);
        longint unsigned acc;
        int k;
        acc = 64'd0;
        for (k = 0; i * (2 * k + 1) <= 60; k++) begin
            acc += udiv(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
        end
        return longint'((acc + (64'd1 << 29)) >> 30);
    endfunction

    // ln(2)/2 = atanh(1/3) in q30
    function automatic longint half_ln2();
        longint unsigned p;
        longint unsigned acc;
        int k;
        p = udiv(64'd1 << 60, 64'd3);
        acc = 64'd0;
        k = 0;
        while (p != 64'd0) begin
            acc += udiv(p, 64'(2 * k + 1));
            p = udiv(p, 64'd9);
            k++;
        end
        return longint'((acc + (64'd1 << 29)) >> 30);
    endfunction

    // tanh(a) in q16 for a >= 0 in q30, hyperbolic rotation mode
    function automatic logic [16:0] cordic_tanh(input longint a);
        longint h;
        longint m;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint tv;
        longint unsigned bg;
        longint unsigned sm;
        longint unsigned den;
        longint unsigned om;
        int i;
        int r;
        int reps;
        h = half_ln2();
        m = longint'(udiv(64'(a), 64'(h)));
        x = longint'(1) << CORDIC_Q;
        y = 0;
        z = a - m * h;
        if (m > 30) m = 30;
        for (i = 1; i <= CORDIC_ITERS; i++) begin
            reps = (i == 4 || i == 13) ? 2 : 1;
            for (r = 0; r < reps; r++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x + dx;
                    y = y + dy;
                    z = z - atanh_pow2(i);
                end else begin
                    x = x - dx;
                    y = y - dy;
                    z = z + atanh_pow2(i);
                end
            end
        end
        if (x + y <= 0 || x - y <= 0) return 17'd0;
        bg = 64'(x + y) << m;
        sm = 64'(x - y);
        den = bg + sm;
        om = udiv((sm << (FRAC_BITS + 1)) + (den >> 1), den);
        tv = (longint'(1) << FRAC_BITS) - longint'(om);
        if (tv < 0) tv = 0;
        return 17'(tv);
    endfunction

    // table entry k of a table sampling tanh on [0, 8]
    function automatic logic [16:0] tanh_entry(input int k, input int depth);
        longint a;
        a = longint'(udiv(64'(k) << (CORDIC_Q + ARG_LOG2), 64'(depth)));
        return cordic_tanh(a);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dynamic_contact_angle.sv =====
`timescale 1ns / 1ps
`default_nettype none

// dynamic contact angle of one wall face, tanh model
// s_ channel: one wall face per item (cell and face velocity, interface normal,
// unit wall normal). m_ channel: one contact angle per item, same order.
// cfg channel: register writes (0 static, 1 speed scale, 2 advancing,
// 3 receding angle); always ready, other indexes are ignored. write only
// while no item is in flight.
// throughput: one item per cycle while the pipe is not held. from acceptance
// to m_tvalid an item passes the 31-step square root, the 17-bit and 19-bit
// restoring dividers (one quotient bit per stage) and the multiply stages.
// all stages move together; when m_tvalid is high and m_tready low the whole
// pipe holds and s_tready drops, nothing is lost or repeated.
// reset (aresetn low, synchronous) empties the pipe and loads the angles
// with 90 degrees and the speed scale with zero (result is the static angle).
module dynamic_contact_angle #(
    parameter int TANH_TABLE_DEPTH = 256
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // cell_vel_x/y/z, face_vel_x/y/z, iface_norm_x/y/z (32 each),
    // wall_norm_x/y/z (18 each), 2 pad bits
    input  wire logic [343:0]                   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // contact_angle
    output logic [31:0]                         m_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                    cfg_data
);
    import dca_pkg::*;

    localparam int KW = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int PW = FRAC_BITS + ARG_LOG2 + KW;

    localparam int STG_G  = 6;
    localparam int STG_J  = 9;
    localparam int STG_UI = STG_J + SQ_STEPS + 1;
    localparam int STG_K  = STG_UI + UQ_BITS + 1;
    localparam int STG_L  = STG_K + 1;
    localparam int STG_M  = STG_L + 1;
    localparam int STG_N  = STG_M + AQ_BITS + 1;
    localparam int STG_P  = STG_N + 2;
    localparam int STG_R  = STG_N + 3;
    localparam int LAT    = STG_N + 6;

    typedef struct packed {
        logic [2:0][29:0] nm;
        logic [2:0]       neg;
        logic [2:0][37:0] uw;
    } dca_pay_t;

    function automatic logic signed [37:0] sat_par(input logic signed [39:0] c);
        if (c > 40'sh10_0000_0000) return 38'sh10_0000_0000;
        if (c < -40'sh10_0000_0000) return -38'sh10_0000_0000;
        return c[37:0];
    endfunction

    // configuration
    logic [23:0] static_reg;
    logic [30:0] scale_reg;
    logic [23:0] adv_reg;
    logic [23:0] rec_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            static_reg <= ANGLE_RESET;
            scale_reg  <= '0;
            adv_reg    <= ANGLE_RESET;
            rec_reg    <= ANGLE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_STATIC_ANGLE:    static_reg <= cfg_data[23:0];
                REG_SPEED_SCALE:     scale_reg  <= cfg_data[30:0];
                REG_ADVANCING_ANGLE: adv_reg    <= cfg_data[23:0];
                REG_RECEDING_ANGLE:  rec_reg    <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // tanh table
    logic [16:0] tanh_rom [TANH_TABLE_DEPTH+1];
    for (genvar g = 0; g <= TANH_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [16:0] ENTRY = tanh_entry(g, TANH_TABLE_DEPTH);
        assign tanh_rom[g] = ENTRY;
    end

    // flow control: the whole pipe advances together
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // input fields
    logic signed [31:0] in_cv [3];
    logic signed [31:0] in_fv [3];
    logic signed [31:0] in_iv [3];
    logic signed [17:0] in_wn [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            in_cv[j] = s_tdata[32*j +: 32];
            in_fv[j] = s_tdata[96 + 32*j +: 32];
            in_iv[j] = s_tdata[192 + 32*j +: 32];
            in_wn[j] = s_tdata[288 + 18*j +: 18];
        end
    end

    // front stages: wall-parallel projection and normalization
    logic signed [32:0] a_rel_reg [3];
    logic signed [31:0] a_nv_reg  [3];
    logic signed [17:0] a_nf_reg  [3];
    logic signed [50:0] b_pu_reg  [3];
    logic signed [49:0] b_pn_reg  [3];
    logic signed [32:0] b_rel_reg [3];
    logic signed [31:0] b_nv_reg  [3];
    logic signed [17:0] b_nf_reg  [3];
    logic signed [36:0] c_du_reg;
    logic signed [36:0] c_dn_reg;
    logic signed [32:0] c_rel_reg [3];
    logic signed [31:0] c_nv_reg  [3];
    logic signed [17:0] c_nf_reg  [3];
    logic signed [54:0] d_qu_reg  [3];
    logic signed [54:0] d_qn_reg  [3];
    logic signed [32:0] d_rel_reg [3];
    logic signed [31:0] d_nv_reg  [3];
    logic signed [37:0] e_uw_reg  [3];
    logic signed [37:0] e_dw_reg  [3];
    logic [36:0]        f_mag_reg [3];
    logic [2:0]         f_neg_reg;
    logic [36:0]        f_mx_reg;
    logic signed [37:0] f_uw_reg  [3];
    logic [5:0]         g_p_reg;
    logic [36:0]        g_mag_reg [3];
    logic [2:0]         g_neg_reg;
    logic signed [37:0] g_uw_reg  [3];
    logic [29:0]        h_nm_reg  [3];
    logic [2:0]         h_neg_reg;
    logic signed [37:0] h_uw_reg  [3];
    logic [59:0]        i_sqm_reg [3];
    dca_pay_t           i_pay_reg;

    logic [52:0] c_su_next;
    logic [52:0] c_sn_next;
    logic [36:0] f_mx_next;
    logic [5:0]  g_p_next;

    always_comb begin
        c_su_next = 53'(b_pu_reg[0]) + 53'(b_pu_reg[1]) + 53'(b_pu_reg[2]);
        c_sn_next = 53'(b_pn_reg[0]) + 53'(b_pn_reg[1]) + 53'(b_pn_reg[2]);
        f_mx_next = (f_mag_reg[0] >= f_mag_reg[1])
                    ? ((f_mag_reg[0] >= f_mag_reg[2]) ? f_mag_reg[0] : f_mag_reg[2])
                    : ((f_mag_reg[1] >= f_mag_reg[2]) ? f_mag_reg[1] : f_mag_reg[2]);
        g_p_next  = '0;
        // highest set bit wins
        for (int b = 0; b < 37; b++) begin
            if (f_mx_next[b]) g_p_next = 6'(b);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                a_rel_reg[j] <= 33'(in_cv[j]) - 33'(in_fv[j]);
                a_nv_reg[j]  <= in_iv[j];
                a_nf_reg[j]  <= in_wn[j];

                b_pu_reg[j]  <= a_rel_reg[j] * a_nf_reg[j];
                b_pn_reg[j]  <= a_nv_reg[j] * a_nf_reg[j];
                b_rel_reg[j] <= a_rel_reg[j];
                b_nv_reg[j]  <= a_nv_reg[j];
                b_nf_reg[j]  <= a_nf_reg[j];

                c_rel_reg[j] <= b_rel_reg[j];
                c_nv_reg[j]  <= b_nv_reg[j];
                c_nf_reg[j]  <= b_nf_reg[j];

                d_qu_reg[j]  <= c_du_reg * c_nf_reg[j];
                d_qn_reg[j]  <= c_dn_reg * c_nf_reg[j];
                d_rel_reg[j] <= c_rel_reg[j];
                d_nv_reg[j]  <= c_nv_reg[j];

                e_uw_reg[j]  <= sat_par(40'(d_rel_reg[j]) - 40'($signed(d_qu_reg[j][54:16])));
                e_dw_reg[j]  <= sat_par(40'(d_nv_reg[j]) - 40'($signed(d_qn_reg[j][54:16])));

                f_neg_reg[j] <= e_dw_reg[j][37];
                f_mag_reg[j] <= e_dw_reg[j][37] ? 37'(-e_dw_reg[j]) : 37'(e_dw_reg[j]);
                f_uw_reg[j]  <= e_uw_reg[j];

                g_mag_reg[j] <= f_mag_reg[j];
                g_uw_reg[j]  <= f_uw_reg[j];

                // largest component lands in [2^29, 2^30)
                if (g_p_reg >= 6'd29) begin
                    h_nm_reg[j] <= 30'(g_mag_reg[j] >> (g_p_reg - 6'd29));
                end else begin
                    h_nm_reg[j] <= 30'({27'b0, g_mag_reg[j]} << (6'd29 - g_p_reg));
                end
                h_uw_reg[j] <= g_uw_reg[j];

                i_sqm_reg[j]     <= {30'b0, h_nm_reg[j]} * {30'b0, h_nm_reg[j]};
                i_pay_reg.nm[j]  <= h_nm_reg[j];
                i_pay_reg.uw[j]  <= h_uw_reg[j];
            end
            c_du_reg  <= 37'($signed(c_su_next[52:16]));
            c_dn_reg  <= 37'($signed(c_sn_next[52:16]));
            f_mx_reg  <= f_mx_next;
            g_p_reg   <= g_p_next;
            g_neg_reg <= f_neg_reg;
            h_neg_reg <= g_neg_reg;
            i_pay_reg.neg <= h_neg_reg;
        end
    end

    // skip flag (zero direction) and speed sign travel on their own lines
    logic [STG_R:STG_G] skp_reg;
    logic [STG_P:STG_L] sng_reg;

    // square root of the squared length, one result bit per stage
    logic [63:0] sq_n_reg   [SQ_STEPS+1];
    logic [63:0] sq_r_reg   [SQ_STEPS+1];
    dca_pay_t    sq_pay_reg [SQ_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_n_reg[0]   <= 64'(i_sqm_reg[0]) + 64'(i_sqm_reg[1]) + 64'(i_sqm_reg[2]);
            sq_r_reg[0]   <= '0;
            sq_pay_reg[0] <= i_pay_reg;
        end
    end

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (2 * (SQ_STEPS - 1 - s));
        logic [63:0] trial;
        logic [63:0] n_next;
        logic [63:0] r_next;

        always_comb begin
            trial = sq_r_reg[s] + BIT;
            if (sq_n_reg[s] >= trial) begin
                n_next = sq_n_reg[s] - trial;
                r_next = (sq_r_reg[s] >> 1) + BIT;
            end else begin
                n_next = sq_n_reg[s];
                r_next = sq_r_reg[s] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_n_reg[s+1]   <= n_next;
                sq_r_reg[s+1]   <= r_next;
                sq_pay_reg[s+1] <= sq_pay_reg[s];
            end
        end
    end

    // unit direction: (nm << 16) / len, three restoring dividers
    logic [30:0]       ud_len_reg [UQ_BITS+1];
    logic [2:0][30:0]  ud_rem_reg [UQ_BITS+1];
    logic [2:0][16:0]  ud_q_reg   [UQ_BITS+1];
    dca_pay_t          ud_pay_reg [UQ_BITS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            ud_len_reg[0] <= sq_r_reg[SQ_STEPS][30:0];
            for (int j = 0; j < 3; j++) begin
                // top dividend bits, the quotient fits in 17 bits
                ud_rem_reg[0][j] <= {2'b0, sq_pay_reg[SQ_STEPS].nm[j][29:1]};
            end
            ud_q_reg[0]   <= '0;
            ud_pay_reg[0] <= sq_pay_reg[SQ_STEPS];
        end
    end

    for (genvar s = 0; s < UQ_BITS; s++) begin : g_udiv
        logic [2:0]       din;
        logic [2:0][31:0] rem2;
        logic [2:0][30:0] rem_next;
        logic [2:0][16:0] q_next;

        for (genvar j = 0; j < 3; j++) begin : g_lane
            if (s == 0) begin : g_lsb
                assign din[j] = ud_pay_reg[s].nm[j][0];
            end else begin : g_zero
                assign din[j] = 1'b0;
            end
        end

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                rem2[j] = {ud_rem_reg[s][j], din[j]};
                if (rem2[j] >= {1'b0, ud_len_reg[s]}) begin
                    rem_next[j] = 31'(rem2[j] - {1'b0, ud_len_reg[s]});
                    q_next[j]   = {ud_q_reg[s][j][15:0], 1'b1};
                end else begin
                    rem_next[j] = rem2[j][30:0];
                    q_next[j]   = {ud_q_reg[s][j][15:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ud_len_reg[s+1] <= ud_len_reg[s];
                ud_rem_reg[s+1] <= rem_next;
                ud_q_reg[s+1]   <= q_next;
                ud_pay_reg[s+1] <= ud_pay_reg[s];
            end
        end
    end

    // contact-line speed
    logic signed [55:0] k_prod_reg [3];
    logic [41:0]        l_ax_reg;
    logic [57:0]        l_sum_next;
    logic signed [41:0] l_speed;
    logic signed [17:0] k_u [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            k_u[j] = ud_pay_reg[UQ_BITS].neg[j] ? -$signed({1'b0, ud_q_reg[UQ_BITS][j]})
                                                : $signed({1'b0, ud_q_reg[UQ_BITS][j]});
        end
        l_sum_next = 58'(k_prod_reg[0]) + 58'(k_prod_reg[1]) + 58'(k_prod_reg[2]);
        l_speed    = $signed(l_sum_next[57:16]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                k_prod_reg[j] <= k_u[j] * $signed(ud_pay_reg[UQ_BITS].uw[j]);
            end
            l_ax_reg <= l_speed[41] ? 42'(-l_speed) : 42'(l_speed);
        end
    end

    // tanh argument: (|speed| << 16) / speed_scale, clamped at 8
    logic [30:0] ad_rem_reg [AQ_BITS+1];
    logic [18:0] ad_q_reg   [AQ_BITS+1];
    logic [2:0]  ad_lo_reg  [AQ_BITS+1];
    logic        ad_big_reg [AQ_BITS+1];
    logic        m_big;

    assign m_big = l_ax_reg >= {8'b0, scale_reg, 3'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            ad_big_reg[0] <= m_big;
            ad_rem_reg[0] <= m_big ? 31'd0 : l_ax_reg[33:3];
            ad_q_reg[0]   <= '0;
            ad_lo_reg[0]  <= l_ax_reg[2:0];
        end
    end

    for (genvar s = 0; s < AQ_BITS; s++) begin : g_adiv
        logic        din;
        logic [31:0] rem2;
        logic [30:0] rem_next;
        logic [18:0] q_next;

        if (AQ_BITS - 1 - s >= FRAC_BITS) begin : g_data
            assign din = ad_lo_reg[s][AQ_BITS - 1 - s - FRAC_BITS];
        end else begin : g_zero
            assign din = 1'b0;
        end

        always_comb begin
            rem2 = {ad_rem_reg[s], din};
            if (rem2 >= {1'b0, scale_reg}) begin
                rem_next = 31'(rem2 - {1'b0, scale_reg});
                q_next   = {ad_q_reg[s][17:0], 1'b1};
            end else begin
                rem_next = rem2[30:0];
                q_next   = {ad_q_reg[s][17:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ad_rem_reg[s+1] <= rem_next;
                ad_q_reg[s+1]   <= q_next;
                ad_lo_reg[s+1]  <= ad_lo_reg[s];
                ad_big_reg[s+1] <= ad_big_reg[s];
            end
        end
    end

    // table lookup, interpolation and final angle
    logic [KW-1:0]      n_k_reg;
    logic [18:0]        n_fr_reg;
    logic [16:0]        o_t0_reg;
    logic signed [17:0] o_dt_reg;
    logic [18:0]        o_fr_reg;
    logic [16:0]        p_t0_reg;
    logic signed [37:0] p_ip_reg;
    logic signed [17:0] q_t_reg;
    logic signed [42:0] r_prod_reg;
    logic [31:0]        out_ang_reg;

    logic [19:0]        n_ax;
    logic [PW-1:0]      n_pos;
    logic               o_sat;
    logic [KW-1:0]      o_i0;
    logic [KW-1:0]      o_i1;
    logic signed [18:0] q_tv;
    logic signed [24:0] r_diff;
    logic [42:0]        out_rnd;
    logic signed [33:0] out_sum;
    logic [31:0]        out_next;

    always_comb begin
        n_ax  = ad_big_reg[AQ_BITS] ? 20'h80000 : {1'b0, ad_q_reg[AQ_BITS]};
        n_pos = PW'(n_ax) * PW'(TANH_TABLE_DEPTH);

        o_sat = n_k_reg >= KW'(TANH_TABLE_DEPTH);
        o_i0  = o_sat ? KW'(TANH_TABLE_DEPTH) : n_k_reg;
        o_i1  = o_sat ? KW'(TANH_TABLE_DEPTH) : n_k_reg + KW'(1);

        q_tv   = $signed({2'b0, p_t0_reg}) + $signed(p_ip_reg[37:19]);
        r_diff = $signed({1'b0, adv_reg}) - $signed({1'b0, rec_reg});

        out_rnd = r_prod_reg + 43'sd32768;
        out_sum = 34'($signed({1'b0, static_reg})) + 34'($signed(out_rnd[42:16]));
        if (skp_reg[STG_R] || scale_reg == '0) begin
            out_next = {8'b0, static_reg};
        end else if (out_sum > 34'sh0_7FFF_FFFF) begin
            out_next = 32'h7FFF_FFFF;
        end else if (out_sum < -34'sh0_8000_0000) begin
            out_next = 32'h8000_0000;
        end else begin
            out_next = out_sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            skp_reg  <= {skp_reg[STG_R-1:STG_G], f_mx_reg == '0};
            sng_reg  <= {sng_reg[STG_P-1:STG_L], l_speed[41]};

            n_k_reg  <= n_pos[PW-1:FRAC_BITS+ARG_LOG2];
            n_fr_reg <= n_pos[FRAC_BITS+ARG_LOG2-1:0];

            o_t0_reg <= tanh_rom[o_i0];
            o_dt_reg <= $signed({1'b0, tanh_rom[o_i1]}) - $signed({1'b0, tanh_rom[o_i0]});
            o_fr_reg <= n_fr_reg;

            p_t0_reg <= o_t0_reg;
            p_ip_reg <= o_dt_reg * $signed({1'b0, o_fr_reg});

            q_t_reg  <= sng_reg[STG_P] ? 18'(-q_tv) : 18'(q_tv);

            r_prod_reg <= r_diff * q_t_reg;

            out_ang_reg <= out_next;
        end
    end

    assign m_tdata = out_ang_reg;

endmodule

`default_nettype wire
